@@ src/ttr_pkg.sv @@
// Shared types, field widths and register codes for the touch tap recognizer.
package ttr_pkg;

   // Field widths fixed by the frame sample format
   localparam int COORD_BITS = 12;
   localparam int FINGER_W   = 4;
   localparam int TIME_W     = 32;
   localparam int SWIPE_W    = 3;

   // Default cap on reported touch points
   localparam int MAX_POINTS_DEF = 8;

   // Configuration register widths and reset values
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SLOP_W     = 10;
   localparam int LIMIT_W    = 16;
   localparam int SLOP_SQ_W  = 2 * SLOP_W;
   localparam int DIST_W     = 2 * COORD_BITS + 1;

   localparam logic [SLOP_W-1:0]    SLOP_FLOOR    = SLOP_W'(12);
   localparam logic [SLOP_SQ_W-1:0] SLOP_SQ_RESET = SLOP_SQ_W'(144);
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = LIMIT_W'(500);

   // Register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] REG_SLOP_RADIUS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TAP_LIMIT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MULTI_LIMIT = 2'd2;

   // Swipe codes
   localparam logic [SWIPE_W-1:0] SWIPE_UP    = 3'd1;
   localparam logic [SWIPE_W-1:0] SWIPE_DOWN  = 3'd2;
   localparam logic [SWIPE_W-1:0] SWIPE_LEFT  = 3'd3;
   localparam logic [SWIPE_W-1:0] SWIPE_RIGHT = 3'd4;

   // One frame sample
   typedef struct packed {
      logic [FINGER_W-1:0]   finger_count;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic [TIME_W-1:0]     time_ms;
      logic [SWIPE_W-1:0]    swipe_code;
      logic                  back_key;
   } req_type;

   // One decision per frame
   typedef struct packed {
      logic                  tap;
      logic [COORD_BITS-1:0] tap_x;
      logic [COORD_BITS-1:0] tap_y;
      logic                  escape;
      logic                  nav_up;
      logic                  nav_down;
      logic                  nav_left;
      logic                  nav_right;
      logic                  any_action;
   } rsp_type;

   // Live configuration handed to the tracker
   typedef struct packed {
      logic [SLOP_SQ_W-1:0] slop_sq;
      logic [LIMIT_W-1:0]   tap_limit;
      logic [LIMIT_W-1:0]   multi_limit;
   } cfg_type;

endpackage

@@ src/touch_tap_recognizer.sv @@
// Top level of the touch tap recognizer: input stage, tracker and result register.
//
// Usage:
//   Frame samples enter on the req_ channel (valid/ready); one decision item
//   per sample leaves on the rsp_ channel (valid/ready). The csr_ port is a
//   plain write port: csr_we, a register index on csr_addr (0 slop radius,
//   1 single-finger tap limit, 2 multi-finger tap limit) and csr_wdata.
//   Write the registers only while no item is in flight.
//   Path: an accepted sample sits in the input register, is decided and
//   lands in the result register, which drives rsp_valid; the item leaves
//   from there. Throughput is one item per cycle while the receiver keeps
//   rsp_ready high, set by the combinational update of the sequence
//   tracker (two 12x12 squares, an add and a compare) between the two
//   registers.
//   Reset (synchronous, high) empties both registers, ends any touch
//   sequence and restores slop 12 and limits of 500 ms.
//   When the receiver stalls, the result register holds its item, the input
//   register still takes one more sample, and req_ready then drops until
//   rsp_ready returns; no item is lost or repeated.
module touch_tap_recognizer #(
   parameter int MAX_POINTS = ttr_pkg::MAX_POINTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ttr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ttr_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [ttr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ttr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ttr_pkg::cfg_type cfg;
   ttr_pkg::req_type in_item_ff;
   ttr_pkg::rsp_type decision;
   ttr_pkg::rsp_type out_item_ff;
   logic             in_vld_ff;
   logic             out_vld_ff;
   logic             advance;

   // Item moves on when the result register is free or being emptied
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   ttr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ttr_track #(
      .MAX_POINTS (MAX_POINTS)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (decision)
   );

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= decision;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_item_ff;

endmodule

@@ src/ttr_csr.sv @@
// Configuration registers: slop radius (held squared) and the two tap limits.
module ttr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ttr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ttr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ttr_pkg::cfg_type                   cfg
);

   logic [ttr_pkg::SLOP_W-1:0]    slop_raw;
   logic [ttr_pkg::SLOP_W-1:0]    slop_clamped;
   logic [ttr_pkg::SLOP_SQ_W-1:0] slop_sq_in;
   logic [ttr_pkg::SLOP_SQ_W-1:0] slop_sq_ff;
   logic [ttr_pkg::LIMIT_W-1:0]   tap_limit_ff;
   logic [ttr_pkg::LIMIT_W-1:0]   multi_limit_ff;

   // Radius below the floor counts as the floor; square it once on write
   assign slop_raw     = csr_wdata[ttr_pkg::SLOP_W-1:0];
   assign slop_clamped = (slop_raw < ttr_pkg::SLOP_FLOOR) ? ttr_pkg::SLOP_FLOOR : slop_raw;
   assign slop_sq_in   = ttr_pkg::SLOP_SQ_W'(slop_clamped) * ttr_pkg::SLOP_SQ_W'(slop_clamped);

   // Register write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         slop_sq_ff     <= ttr_pkg::SLOP_SQ_RESET;
         tap_limit_ff   <= ttr_pkg::LIMIT_RESET;
         multi_limit_ff <= ttr_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            ttr_pkg::REG_SLOP_RADIUS: slop_sq_ff     <= slop_sq_in;
            ttr_pkg::REG_TAP_LIMIT:   tap_limit_ff   <= csr_wdata[ttr_pkg::LIMIT_W-1:0];
            ttr_pkg::REG_MULTI_LIMIT: multi_limit_ff <= csr_wdata[ttr_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.slop_sq     = slop_sq_ff;
   assign cfg.tap_limit   = tap_limit_ff;
   assign cfg.multi_limit = multi_limit_ff;

endmodule

@@ src/ttr_track.sv @@
// Touch sequence state and the per-frame tap / escape / swipe decision.
module ttr_track #(
   parameter int MAX_POINTS = ttr_pkg::MAX_POINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  ttr_pkg::req_type item,
   input  ttr_pkg::cfg_type cfg,
   output ttr_pkg::rsp_type result
);

   localparam int PEAK_W = $clog2(MAX_POINTS + 1);
   localparam int CB     = ttr_pkg::COORD_BITS;
   localparam int SQ_W   = 2 * CB;

   logic                     seq_active_ff, seq_active_in;
   logic [CB-1:0]            start_x_ff, start_x_in;
   logic [CB-1:0]            start_y_ff, start_y_in;
   logic [CB-1:0]            recent_x_ff, recent_x_in;
   logic [CB-1:0]            recent_y_ff, recent_y_in;
   logic [ttr_pkg::TIME_W-1:0] start_time_ff, start_time_in;
   logic [PEAK_W-1:0]        peak_ff, peak_in;
   logic                     drifted_ff, drifted_in;

   logic [PEAK_W-1:0]        fingers;
   logic                     touching;
   logic                     new_seq;
   logic [CB-1:0]            base_x, base_y;
   logic [PEAK_W-1:0]        base_peak;
   logic [CB-1:0]            dx, dy;
   logic [SQ_W-1:0]          dx_sq, dy_sq;
   logic [ttr_pkg::DIST_W-1:0] dist_sq;
   logic                     beyond_slop;
   logic [ttr_pkg::TIME_W-1:0] duration;
   logic                     release_seq;
   logic                     tap;
   logic                     escape;

   // Finger count capped at the point limit
   assign fingers  = (item.finger_count > ttr_pkg::FINGER_W'(MAX_POINTS))
                     ? PEAK_W'(MAX_POINTS) : PEAK_W'(item.finger_count);
   assign touching = (item.finger_count != '0);
   assign new_seq  = touching && !seq_active_ff;

   // A fresh sequence starts from the current point
   assign base_x    = new_seq ? item.point_x : start_x_ff;
   assign base_y    = new_seq ? item.point_y : start_y_ff;
   assign base_peak = new_seq ? '0 : peak_ff;

   // Squared distance from the start point against the squared slop
   assign dx          = (item.point_x >= base_x) ? item.point_x - base_x : base_x - item.point_x;
   assign dy          = (item.point_y >= base_y) ? item.point_y - base_y : base_y - item.point_y;
   assign dx_sq       = SQ_W'(dx) * SQ_W'(dx);
   assign dy_sq       = SQ_W'(dy) * SQ_W'(dy);
   assign dist_sq     = ttr_pkg::DIST_W'(dx_sq) + ttr_pkg::DIST_W'(dy_sq);
   assign beyond_slop = dist_sq > ttr_pkg::DIST_W'(cfg.slop_sq);

   // Release decision, duration wraps modulo 2^32
   assign release_seq = !touching && seq_active_ff;
   assign duration    = item.time_ms - start_time_ff;

   // Next state of the sequence tracker
   always_comb begin
      seq_active_in = seq_active_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      recent_x_in   = recent_x_ff;
      recent_y_in   = recent_y_ff;
      start_time_in = start_time_ff;
      peak_in       = peak_ff;
      drifted_in    = drifted_ff;
      tap           = 1'b0;
      escape        = 1'b0;
      if (touching) begin
         seq_active_in = 1'b1;
         start_x_in    = base_x;
         start_y_in    = base_y;
         recent_x_in   = new_seq ? item.point_x : recent_x_ff;
         recent_y_in   = new_seq ? item.point_y : recent_y_ff;
         start_time_in = new_seq ? item.time_ms : start_time_ff;
         drifted_in    = new_seq ? 1'b0 : drifted_ff;
         peak_in       = (fingers > base_peak) ? fingers : base_peak;
         // Movement only tracked while the sequence stays single-finger
         if (peak_in < PEAK_W'(2)) begin
            drifted_in  = drifted_in | beyond_slop;
            recent_x_in = item.point_x;
            recent_y_in = item.point_y;
         end
      end else if (release_seq) begin
         seq_active_in = 1'b0;
         if (peak_ff >= PEAK_W'(2)) begin
            escape = duration < ttr_pkg::TIME_W'(cfg.multi_limit);
         end else begin
            tap = !drifted_ff && (duration < ttr_pkg::TIME_W'(cfg.tap_limit));
         end
      end
   end

   // Tracker registers move only when an item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
      end else if (step) begin
         seq_active_ff <= seq_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         recent_x_ff   <= recent_x_in;
         recent_y_ff   <= recent_y_in;
         start_time_ff <= start_time_in;
         peak_ff       <= peak_in;
         drifted_ff    <= drifted_in;
      end
   end

   // Result fields
   always_comb begin
      result.tap        = tap;
      result.tap_x      = tap ? recent_x_ff : '0;
      result.tap_y      = tap ? recent_y_ff : '0;
      result.escape     = escape | item.back_key;
      result.nav_up     = (item.swipe_code == ttr_pkg::SWIPE_UP);
      result.nav_down   = (item.swipe_code == ttr_pkg::SWIPE_DOWN);
      result.nav_left   = (item.swipe_code == ttr_pkg::SWIPE_LEFT);
      result.nav_right  = (item.swipe_code == ttr_pkg::SWIPE_RIGHT);
      result.any_action = tap | escape | item.back_key;
   end

endmodule

@@ tb/tb_touch_tap_recognizer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the touch tap recognizer: directed table, then random gestures.
module tb_touch_tap_recognizer;
   import ttr_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int FRAME_GOAL  = 1900;
   localparam int PHASES      = 6;
   localparam int SHOWN_MAX   = 10;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

   localparam logic [FINGER_W-1:0] FINGER_CAP  = FINGER_W'(MAX_POINTS_DEF);
   localparam logic [SWIPE_W-1:0]  SWIPE_NONE  = 3'd0;
   localparam logic [SWIPE_W-1:0]  SWIPE_BOGUS = 3'd7;

   // Expected nav flags, packed as {up, down, left, right}
   localparam logic [3:0] NAV_NONE  = 4'b0000;
   localparam logic [3:0] NAV_UP    = 4'b1000;
   localparam logic [3:0] NAV_DOWN  = 4'b0100;
   localparam logic [3:0] NAV_LEFT  = 4'b0010;
   localparam logic [3:0] NAV_RIGHT = 4'b0001;

   typedef enum {G_TAP, G_DRAG, G_MULTI, G_LONG, G_NOISE, G_RELEASE} gesture_e;
   typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_BURSTY} rx_mode_e;

   // One step of the directed table: a register write or a frame
   typedef struct {
      bit                    is_write;
      logic [CSR_ADDR_W-1:0] idx;
      logic [CSR_DATA_W-1:0] val;
      req_type               frame;
      bit                    fixed;
      rsp_type               want;
   } plan_row;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   touch_tap_recognizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Register mirror
   logic [SLOP_W-1:0]  mir_slop        = SLOP_FLOOR;
   logic [LIMIT_W-1:0] mir_tap_limit   = LIMIT_RESET;
   logic [LIMIT_W-1:0] mir_multi_limit = LIMIT_RESET;

   // Touch sequence tracker copy
   logic                  trk_active   = 1'b0;
   logic [COORD_BITS-1:0] trk_start_x  = '0;
   logic [COORD_BITS-1:0] trk_start_y  = '0;
   logic [COORD_BITS-1:0] trk_last_x   = '0;
   logic [COORD_BITS-1:0] trk_last_y   = '0;
   logic [TIME_W-1:0]     trk_start_ms = '0;
   logic [FINGER_W-1:0]   trk_peak     = '0;
   logic                  trk_drifted  = 1'b0;

   rsp_type     pending_decisions[$];
   plan_row     directed_plan[$];
   logic [TIME_W-1:0] stamp_ms = '0;

   int mismatch_count = 0;
   int frames_sent    = 0;
   int decisions_seen = 0;
   int taps_seen      = 0;
   int escapes_seen   = 0;
   int reg_writes     = 0;
   int burst_left     = 0;

   function automatic longint unsigned sq_gap(logic [COORD_BITS-1:0] a, logic [COORD_BITS-1:0] b);
      longint unsigned d;
      d = (a > b) ? 64'(a - b) : 64'(b - a);
      return d * d;
   endfunction

   // Decision for one frame; advances the tracker copy
   function automatic rsp_type decide_frame(req_type f);
      rsp_type             r;
      logic [FINGER_W-1:0] fingers;
      logic [TIME_W-1:0]   span;
      longint unsigned     slop_eff;
      r = '0;
      fingers = (f.finger_count > FINGER_CAP) ? FINGER_CAP : f.finger_count;
      if (fingers != 0) begin
         if (!trk_active) begin
            trk_active   = 1'b1;
            trk_start_x  = f.point_x;
            trk_start_y  = f.point_y;
            trk_last_x   = f.point_x;
            trk_last_y   = f.point_y;
            trk_start_ms = f.time_ms;
            trk_peak     = '0;
            trk_drifted  = 1'b0;
         end
         if (fingers > trk_peak)
            trk_peak = fingers;
         // position only tracked while the sequence stays single-finger
         if (trk_peak < 2) begin
            slop_eff = 64'((mir_slop < SLOP_FLOOR) ? SLOP_FLOOR : mir_slop);
            if (sq_gap(f.point_x, trk_start_x) + sq_gap(f.point_y, trk_start_y)
                > slop_eff * slop_eff)
               trk_drifted = 1'b1;
            trk_last_x = f.point_x;
            trk_last_y = f.point_y;
         end
      end else if (trk_active) begin
         // release: duration wraps modulo 2^32
         span = f.time_ms - trk_start_ms;
         if (trk_peak >= 2) begin
            r.escape = (span < mir_multi_limit);
         end else if (!trk_drifted && span < mir_tap_limit) begin
            r.tap   = 1'b1;
            r.tap_x = trk_last_x;
            r.tap_y = trk_last_y;
         end
         trk_active = 1'b0;
      end
      if (f.back_key)
         r.escape = 1'b1;
      r.nav_up     = (f.swipe_code == SWIPE_UP);
      r.nav_down   = (f.swipe_code == SWIPE_DOWN);
      r.nav_left   = (f.swipe_code == SWIPE_LEFT);
      r.nav_right  = (f.swipe_code == SWIPE_RIGHT);
      r.any_action = r.tap | r.escape;
      return r;
   endfunction

   function automatic req_type mk_frame(int fc, int x, int y, logic [TIME_W-1:0] t,
                                        logic [SWIPE_W-1:0] sw, bit bk);
      req_type f;
      f.finger_count = fc[FINGER_W-1:0];
      f.point_x      = x[COORD_BITS-1:0];
      f.point_y      = y[COORD_BITS-1:0];
      f.time_ms      = t;
      f.swipe_code   = sw;
      f.back_key     = bk;
      return f;
   endfunction

   function automatic rsp_type mk_rsp(bit tap, int x, int y, bit esc, logic [3:0] nav);
      rsp_type r;
      r.tap        = tap;
      r.tap_x      = x[COORD_BITS-1:0];
      r.tap_y      = y[COORD_BITS-1:0];
      r.escape     = esc;
      r.nav_up     = nav[3];
      r.nav_down   = nav[2];
      r.nav_left   = nav[1];
      r.nav_right  = nav[0];
      r.any_action = tap | esc;
      return r;
   endfunction

   task automatic add_frame(req_type f, bit fixed, rsp_type want);
      plan_row row;
      row.is_write = 1'b0;
      row.idx      = '0;
      row.val      = '0;
      row.frame    = f;
      row.fixed    = fixed;
      row.want     = want;
      directed_plan.push_back(row);
   endtask

   task automatic add_write(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      plan_row row;
      row.is_write = 1'b1;
      row.idx      = idx;
      row.val      = val;
      row.frame    = '0;
      row.fixed    = 1'b0;
      row.want     = '0;
      directed_plan.push_back(row);
   endtask

   // Offer one item, in bursts with random gaps between them
   task automatic send_frame(req_type f, bit fixed, rsp_type want);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (!req_ready);
      predicted = decide_frame(f);
      pending_decisions.push_back(fixed ? want : predicted);
      frames_sent++;
   endtask

   // Drain: drop req_valid and wait for every decision back, then idle
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SLOP_RADIUS: mir_slop        = val[SLOP_W-1:0];
         REG_TAP_LIMIT:   mir_tap_limit   = val[LIMIT_W-1:0];
         REG_MULTI_LIMIT: mir_multi_limit = val[LIMIT_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // One gesture: a run of touch frames and a release, or a run of noise or bare release frames
   task automatic play_gesture();
      gesture_e           style;
      int                 pick, n, fc, dx, dy, s, slop_eff, x0, y0, xi, yi, forced;
      logic [LIMIT_W-1:0] lim;
      logic [TIME_W-1:0]  dur;
      req_type            f;
      rsp_type            none;
      none = '0;
      pick = $urandom_range(0, 9);
      style = (pick < 4) ? G_TAP : (pick == 4) ? G_DRAG : (pick < 7) ? G_MULTI :
              (pick == 7) ? G_LONG : (pick == 8) ? G_NOISE : G_RELEASE;
      n = $urandom_range(1, 5);
      forced = $urandom_range(0, n - 1);
      // occasional jump of the clock, often close to the wrap
      if ($urandom_range(0, 30) == 0)
         stamp_ms = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 2000);

      if (style == G_NOISE || style == G_RELEASE) begin
         repeat (n) begin
            fc = (style == G_NOISE) ? $urandom_range(0, 15) : 0;
            f = mk_frame(fc, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         (style == G_NOISE) ? $urandom() : stamp_ms,
                         SWIPE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            send_frame(f, 1'b0, none);
            stamp_ms += $urandom_range(0, 200);
         end
         return;
      end

      lim = (style == G_MULTI) ? mir_multi_limit : mir_tap_limit;
      if (style == G_LONG)
         dur = lim + $urandom_range(0, 3000);
      else if ($urandom_range(0, 3) == 0)
         dur = (lim > 0) ? lim - $urandom_range(0, 1) : '0;
      else
         dur = $urandom_range(0, lim + lim / 4);

      slop_eff = int'((mir_slop < SLOP_FLOOR) ? SLOP_FLOOR : mir_slop);
      s  = slop_eff * 7 / 10;
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
      for (int i = 0; i < n; i++) begin
         fc = 1;
         xi = x0;
         yi = y0;
         if (style == G_DRAG) begin
            xi = $urandom_range(0, COORD_MAX);
            yi = $urandom_range(0, COORD_MAX);
         end else if (style == G_MULTI) begin
            fc = (i == forced) ? $urandom_range(2, 15) : $urandom_range(1, 15);
            xi = $urandom_range(0, COORD_MAX);
            yi = $urandom_range(0, COORD_MAX);
         end else if (i > 0) begin
            // stay inside the slop circle, or sit right on its edge or just past it
            if ($urandom_range(0, 7) == 0) begin
               dx = slop_eff + $urandom_range(0, 1);
               dy = 0;
            end else begin
               dx = int'($urandom_range(0, 2 * s)) - s;
               dy = int'($urandom_range(0, 2 * s)) - s;
            end
            xi = (x0 + dx < 0) ? 0 : (x0 + dx > COORD_MAX) ? COORD_MAX : x0 + dx;
            yi = (y0 + dy < 0) ? 0 : (y0 + dy > COORD_MAX) ? COORD_MAX : y0 + dy;
         end
         f = mk_frame(fc, xi, yi, stamp_ms + (dur * i) / n, SWIPE_W'($urandom_range(0, 7)),
                      ($urandom_range(0, 9) == 0));
         send_frame(f, 1'b0, none);
      end
      f = mk_frame(0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   stamp_ms + dur, SWIPE_W'($urandom_range(0, 7)),
                   ($urandom_range(0, 9) == 0));
      send_frame(f, 1'b0, none);
      stamp_ms += dur + $urandom_range(0, 2000);
   endtask

   // Main sequence
   initial begin : stimulus
      plan_row               row;
      int                    phase_goal;
      logic [CSR_DATA_W-1:0] slop_val, tap_val, multi_val;

      // idle frames: back key, each swipe code, unknown swipe
      add_frame(mk_frame(0, COORD_MAX, COORD_MAX, 0, SWIPE_NONE, 1), 1,
                mk_rsp(0, 0, 0, 1, NAV_NONE));
      add_frame(mk_frame(0, 0, 0, 0, SWIPE_UP, 0), 1, mk_rsp(0, 0, 0, 0, NAV_UP));
      add_frame(mk_frame(0, 0, 0, 0, SWIPE_DOWN, 0), 1, mk_rsp(0, 0, 0, 0, NAV_DOWN));
      add_frame(mk_frame(0, 0, 0, 0, SWIPE_LEFT, 0), 1, mk_rsp(0, 0, 0, 0, NAV_LEFT));
      add_frame(mk_frame(0, 0, 0, 0, SWIPE_RIGHT, 0), 1, mk_rsp(0, 0, 0, 0, NAV_RIGHT));
      add_frame(mk_frame(0, COORD_MAX, COORD_MAX, 0, SWIPE_BOGUS, 0), 1,
                mk_rsp(0, 0, 0, 0, NAV_NONE));
      // plain tap at the latest position
      add_frame(mk_frame(1, 100, 200, 1000, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(1, 105, 205, 1100, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(0, 0, 0, 1200, SWIPE_NONE, 0), 1, mk_rsp(1, 105, 205, 0, NAV_NONE));
      // too many fingers, across the timestamp wrap: escape
      add_frame(mk_frame(15, COORD_MAX, COORD_MAX, 32'hFFFF_FFF0, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(1, 0, 0, 32'hFFFF_FFF8, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(0, 0, 0, 32'h0000_0010, SWIPE_NONE, 0), 1,
                mk_rsp(0, 0, 0, 1, NAV_NONE));
      // corner to corner drag: nothing
      add_frame(mk_frame(1, 0, 0, 0, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(1, COORD_MAX, COORD_MAX, 10, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(0, 0, 0, 20, SWIPE_NONE, 0), 1, mk_rsp(0, 0, 0, 0, NAV_NONE));
      // slop below the floor, move exactly on the floor radius, shortest limit
      add_write(REG_SLOP_RADIUS, 16'd0);
      add_write(REG_TAP_LIMIT, 16'd1);
      add_frame(mk_frame(1, 2000, 2000, 50, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(1, 2012, 2000, 50, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(0, 0, 0, 50, SWIPE_NONE, 0), 1, mk_rsp(1, 2012, 2000, 0, NAV_NONE));
      // zero limits: neither tap nor escape
      add_write(REG_TAP_LIMIT, 16'd0);
      add_write(REG_MULTI_LIMIT, 16'd0);
      add_frame(mk_frame(1, 7, 7, 5, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(0, 0, 0, 5, SWIPE_NONE, 0), 1, mk_rsp(0, 0, 0, 0, NAV_NONE));
      add_frame(mk_frame(2, 7, 7, 5, SWIPE_NONE, 0), 0, '0);
      add_frame(mk_frame(0, 0, 0, 5, SWIPE_NONE, 0), 1, mk_rsp(0, 0, 0, 0, NAV_NONE));

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.is_write) begin
            settle();
            write_reg(row.idx, row.val);
         end else begin
            send_frame(row.frame, row.fixed, row.want);
         end
      end

      // random gestures under several register settings
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin slop_val = 16'd12; tap_val = 16'd500; multi_val = 16'd500; end
            1: begin slop_val = 16'd1023; tap_val = 16'hFFFF; multi_val = 16'hFFFF; end
            2: begin
               slop_val  = CSR_DATA_W'($urandom_range(0, 11));
               tap_val   = 16'd1;
               multi_val = 16'd1;
            end
            3: begin
               slop_val  = CSR_DATA_W'($urandom_range(12, 1023));
               tap_val   = CSR_DATA_W'($urandom_range(1, 2000));
               multi_val = CSR_DATA_W'($urandom_range(1, 2000));
            end
            4: begin slop_val = 16'd12; tap_val = 16'd0; multi_val = 16'hFFFF; end
            default: begin
               slop_val  = CSR_DATA_W'($urandom_range(0, 1023));
               tap_val   = CSR_DATA_W'($urandom_range(0, 65535));
               multi_val = CSR_DATA_W'($urandom_range(0, 65535));
            end
         endcase
         write_reg(REG_SLOP_RADIUS, slop_val);
         write_reg(REG_TAP_LIMIT, tap_val);
         write_reg(REG_MULTI_LIMIT, multi_val);
         phase_goal = frames_sent + FRAME_GOAL / PHASES;
         while (frames_sent < phase_goal)
            play_gesture();
      end

      settle();
      repeat (8) @(posedge clock);

      $display("Covered %0d frames and %0d register writes; %0d decisions checked",
               frames_sent, reg_writes, decisions_seen);
      $display("Decisions held %0d taps and %0d escapes; %0d mismatches",
               taps_seen, escapes_seen, mismatch_count);
      if (mismatch_count == 0 && pending_decisions.size() == 0)
         $display("[touch_tap_recognizer] OK");
      else
         $display("[touch_tap_recognizer] ERROR");
      $finish;
   end

   // Receiver stalls on its own pattern, switching mode now and then
   initial begin : receiver_pacing
      rx_mode_e mode;
      int       mode_left, run_left;
      logic     level;
      mode      = RX_OPEN;
      mode_left = 0;
      run_left  = 0;
      level     = 1'b1;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = rx_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if (run_left == 0) begin
                  level    = ~level;
                  run_left = $urandom_range(1, 20);
               end
               run_left--;
               rsp_ready <= level;
            end
         endcase
      end
   end

   task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < SHOWN_MAX)
            $display("Mismatch on %s at %0t: expected %0h, got %0h", name, $realtime, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_decisions
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decisions.size() == 0) begin
            if (mismatch_count < SHOWN_MAX)
               $display("Unexpected item at %0t: %p", $realtime, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_decisions.pop_front();
            note_field("tap", want.tap, rsp_data.tap);
            note_field("tap_x", want.tap_x, rsp_data.tap_x);
            note_field("tap_y", want.tap_y, rsp_data.tap_y);
            note_field("escape", want.escape, rsp_data.escape);
            note_field("nav_up", want.nav_up, rsp_data.nav_up);
            note_field("nav_down", want.nav_down, rsp_data.nav_down);
            note_field("nav_left", want.nav_left, rsp_data.nav_left);
            note_field("nav_right", want.nav_right, rsp_data.nav_right);
            note_field("any_action", want.any_action, rsp_data.any_action);
            decisions_seen++;
            taps_seen    += want.tap;
            escapes_seen += want.escape;
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      #4_000_000;
      $display("[touch_tap_recognizer] ERROR");
      $finish;
   end

endmodule
